// ----- rtl/vpts_pkg.sv -----
`timescale 1ns / 1ps
package vpts_pkg;

	// Field and coefficient formats
	localparam int CW     = 32;          // coordinate width, Q16.16
	localparam int F      = CW / 2;      // coordinate fraction bits
	localparam int KW     = 16;          // coefficient width, Q3.12
	localparam int KF     = KW - 4;      // coefficient fraction bits
	localparam int PRD_W  = CW + KW;     // one coefficient times one coordinate
	localparam int CLIP_W = PRD_W + 2;   // clip value, signed
	localparam int MAG_W  = CLIP_W - 1;  // clip magnitude
	localparam int QB     = F + 18;      // quotient bits kept by the divider
	localparam int NDC_W  = QB + 1;      // signed, clamped quotient
	localparam int SX_W   = NDC_W + 1;   // ndc offset by one
	localparam int VP_W   = 14;          // viewport register width
	localparam int PX_W   = SX_W + VP_W + 1;

	// Configuration port
	localparam int ROW_W  = 64;
	localparam int IDX_W  = 3;

	// Pipeline: products, clip sums, divider setup, QB divider steps,
	// quotient clamp, viewport product, output register
	localparam int DIV0   = 2;
	localparam int NPIPE  = DIV0 + QB + 4;

	// Quotient magnitude clamp, 2^(CW+1)
	localparam logic [QB-1:0] CAP = {1'b1, {(QB-1){1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_ROW0 = 3'd0,
		REG_ROW1 = 3'd1,
		REG_ROW2 = 3'd2,
		REG_ROW3 = 3'd3,
		REG_VP_W = 3'd4,
		REG_VP_H = 3'd5
	} cfg_reg_t;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QB-1:0]    dd;    // dividend bits still to bring down
		logic [QB-1:0]    q;
		logic             ovf;   // quotient at or beyond 2^QB
		logic             neg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0]  lane;
		logic [MAG_W-1:0] den;
		logic             wz;
	} div_st_t;

	// One restoring-division step: bring down a bit, subtract if it fits.
	function automatic div_lane_t div_step(div_lane_t a, logic [MAG_W-1:0] den);
		logic [MAG_W:0] r2;
		logic [MAG_W:0] df;
		div_lane_t      o;
		o  = a;
		r2 = {a.rem, a.dd[QB-1]};
		df = r2 - {1'b0, den};
		if (r2 >= {1'b0, den}) begin
			o.rem = df[MAG_W-1:0];
			o.q   = {a.q[QB-2:0], 1'b1};
		end else begin
			o.rem = r2[MAG_W-1:0];
			o.q   = {a.q[QB-2:0], 1'b0};
		end
		o.dd = {a.dd[QB-2:0], 1'b0};
		return o;
	endfunction

endpackage

// ----- rtl/vpts_vertex_if.sv -----
`timescale 1ns / 1ps
interface vpts_vertex_if;
	import vpts_pkg::*;
	logic   valid;
	logic   ready;
	coord_t world_x;
	coord_t world_y;
	coord_t world_z;
	modport source (output valid, world_x, world_y, world_z, input ready);
	modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

// ----- rtl/vpts_screen_if.sv -----
`timescale 1ns / 1ps
interface vpts_screen_if;
	import vpts_pkg::*;
	logic   valid;
	logic   ready;
	coord_t screen_x;
	coord_t screen_y;
	coord_t screen_depth;
	logic   w_zero;
	logic   clipped_range;
	modport source (output valid, screen_x, screen_y, screen_depth, w_zero, clipped_range,
		input ready);
	modport sink (input valid, screen_x, screen_y, screen_depth, w_zero, clipped_range,
		output ready);
endinterface

// ----- rtl/vpts_cfg_if.sv -----
`timescale 1ns / 1ps
interface vpts_cfg_if;
	import vpts_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [ROW_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/vertex_project_to_screen.sv -----
`timescale 1ns / 1ps
// Perspective projection of world-space vertices to viewport pixels.
//
// vertex (sink): one world position per transaction, x/y/z signed Q16.16.
// screen (source): one result per vertex, in order: screen x/y in pixels
//   (Q16.16, y from the top), depth as ndc z, w_zero when clip w was zero
//   (coordinates then 0), clipped_range when any coordinate saturated.
// cfg (sink): register writes, index 0..3 are the packed matrix rows
//   (four signed Q3.12 coefficients, column 0 in the low bits), 4 and 5 the
//   viewport width and height. Write only while no vertex is in flight.
//   Writes to other indexes are ignored; cfg.ready is always high.
//
// Throughput: one vertex per cycle while screen is not stalling. The depth
// comes from the divider, one quotient bit per stage for 34 bits, shared by
// the three lanes that divide by clip w.
// Reset clears all pipeline valid bits and loads the identity matrix and a
// 640x480 viewport. When screen stalls, each stage holds only once all later
// stages are full, so bubbles close up and vertex.ready stays high until the
// whole pipe is occupied.
module vertex_project_to_screen (
	input  logic                      clk,
	input  logic                      arst_n,
	vpts_vertex_if.sink               vertex,
	vpts_screen_if.source             screen,
	vpts_cfg_if.sink                  cfg
);
	import vpts_pkg::*;

	typedef struct packed {
		logic   f;
		coord_t v;
	} sat_t;

	// Clamp to the coordinate range, report whether clamping happened.
	function automatic sat_t sat_coord(logic signed [PX_W-1:0] v);
		sat_t o;
		o.f = !((&v[PX_W-1:CW-1]) || !(|v[PX_W-1:CW-1]));
		if (!o.f) begin
			o.v = v[CW-1:0];
		end else if (v[PX_W-1]) begin
			o.v = {1'b1, {(CW-1){1'b0}}};
		end else begin
			o.v = {1'b0, {(CW-1){1'b1}}};
		end
		return o;
	endfunction

	function automatic logic [MAG_W-1:0] mag(logic signed [CLIP_W-1:0] v);
		logic [CLIP_W-1:0] n;
		n = v[CLIP_W-1] ? (~v + 1'b1) : v;
		return n[MAG_W-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic [ROW_W-1:0] row_q [4];
	logic [VP_W-1:0]  vp_w_q;
	logic [VP_W-1:0]  vp_h_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW_W'(1) << KF;
			row_q[1] <= ROW_W'(1) << (KF + KW);
			row_q[2] <= ROW_W'(1) << (KF + 2 * KW);
			row_q[3] <= ROW_W'(1) << (KF + 3 * KW);
			vp_w_q   <= VP_W'(640);
			vp_h_q   <= VP_W'(480);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROW0: row_q[0] <= cfg.data;
				REG_ROW1: row_q[1] <= cfg.data;
				REG_ROW2: row_q[2] <= cfg.data;
				REG_ROW3: row_q[3] <= cfg.data;
				REG_VP_W: vp_w_q   <= cfg.data[VP_W-1:0];
				REG_VP_H: vp_h_q   <= cfg.data[VP_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [KW-1:0] coef [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				coef[r][c] = row_q[r][c*KW +: KW];
			end
		end
	end

	// ---------------- flow control ----------------
	// A stage may load when it, or any stage after it, has a hole, or the
	// output transaction completes this cycle.
	logic [NPIPE-1:0] stage_valid_q;
	logic [NPIPE-1:0] en;

	for (genvar gk = 0; gk < NPIPE; gk++) begin : g_en
		localparam logic [NPIPE-1:0] LOW = NPIPE'((64'd1 << gk) - 64'd1);
		assign en[gk] = screen.ready || !(&(stage_valid_q | LOW));
	end

	assign vertex.ready = en[0];
	assign screen.valid = stage_valid_q[NPIPE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[0]) stage_valid_q[0] <= vertex.valid;
			for (int k = 1; k < NPIPE; k++) begin
				if (en[k]) stage_valid_q[k] <= stage_valid_q[k-1];
			end
		end
	end

	// ---------------- stage 1: coefficient products ----------------
	logic signed [PRD_W-1:0] prod_s1 [4][3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= coef[r][0] * vertex.world_x;
				prod_s1[r][1] <= coef[r][1] * vertex.world_y;
				prod_s1[r][2] <= coef[r][2] * vertex.world_z;
			end
		end
	end

	// ---------------- stage 2: clip sums, w term is coef * 1.0 ----------------
	logic signed [CLIP_W-1:0] clip_s2 [4];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 4; r++) begin
				clip_s2[r] <= CLIP_W'(prod_s1[r][0]) + CLIP_W'(prod_s1[r][1])
					+ CLIP_W'(prod_s1[r][2]) + (CLIP_W'(coef[r][3]) <<< F);
			end
		end
	end

	// ---------------- divider: setup then one quotient bit per stage ----------------
	div_st_t div_s [QB+1];
	div_st_t div_init;

	always_comb begin
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] top;
		div_init.den = mag(clip_s2[3]);
		div_init.wz  = (clip_s2[3] == '0);
		for (int l = 0; l < 3; l++) begin
			a   = mag(clip_s2[l]);
			top = a >> (QB - F);
			div_init.lane[l].neg = clip_s2[l][CLIP_W-1] ^ clip_s2[3][CLIP_W-1];
			div_init.lane[l].ovf = (top >= div_init.den);
			div_init.lane[l].rem = top;
			div_init.lane[l].dd  = {a[QB-F-1:0], {F{1'b0}}};
			div_init.lane[l].q   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV0]) div_s[0] <= div_init;
	end

	for (genvar gs = 1; gs <= QB; gs++) begin : g_div
		always_ff @(posedge clk) begin
			if (en[DIV0+gs]) begin
				div_s[gs].den <= div_s[gs-1].den;
				div_s[gs].wz  <= div_s[gs-1].wz;
				for (int l = 0; l < 3; l++) begin
					div_s[gs].lane[l] <= div_step(div_s[gs-1].lane[l], div_s[gs-1].den);
				end
			end
		end
	end

	// ---------------- stage 4: clamp and sign the quotients ----------------
	logic signed [NDC_W-1:0] ndc_s4 [3];
	logic                    wz_s4;

	always_ff @(posedge clk) begin
		logic [QB-1:0] qf;
		if (en[DIV0+QB+1]) begin
			wz_s4 <= div_s[QB].wz;
			for (int l = 0; l < 3; l++) begin
				qf = (div_s[QB].lane[l].ovf || div_s[QB].lane[l].q > CAP) ?
					CAP : div_s[QB].lane[l].q;
				ndc_s4[l] <= div_s[QB].lane[l].neg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
			end
		end
	end

	// ---------------- stage 5: viewport products ----------------
	logic signed [PX_W-1:0]  px_s5;
	logic signed [PX_W-1:0]  py_s5;
	logic signed [NDC_W-1:0] nz_s5;
	logic                    wz_s5;

	always_ff @(posedge clk) begin
		logic signed [SX_W-1:0] sx;
		logic signed [SX_W-1:0] sy;
		if (en[DIV0+QB+2]) begin
			sx    = SX_W'(ndc_s4[0]) + (SX_W'(1) <<< F);
			sy    = (SX_W'(1) <<< F) - SX_W'(ndc_s4[1]);
			px_s5 <= sx * $signed({1'b0, vp_w_q});
			py_s5 <= sy * $signed({1'b0, vp_h_q});
			nz_s5 <= ndc_s4[2];
			wz_s5 <= wz_s4;
		end
	end

	// ---------------- output register: halve, saturate, zero-w override ----------------
	sat_t sx_c;
	sat_t sy_c;
	sat_t sz_c;

	always_comb begin
		logic signed [PX_W-1:0] hx;
		logic signed [PX_W-1:0] hy;
		hx   = (px_s5 + $signed(PX_W'(px_s5[PX_W-1]))) >>> 1;
		hy   = (py_s5 + $signed(PX_W'(py_s5[PX_W-1]))) >>> 1;
		sx_c = sat_coord(hx);
		sy_c = sat_coord(hy);
		sz_c = sat_coord(PX_W'(nz_s5));
	end

	always_ff @(posedge clk) begin
		if (en[NPIPE-1]) begin
			if (wz_s5) begin
				screen.screen_x      <= '0;
				screen.screen_y      <= '0;
				screen.screen_depth  <= '0;
				screen.w_zero        <= 1'b1;
				screen.clipped_range <= 1'b0;
			end else begin
				screen.screen_x      <= sx_c.v;
				screen.screen_y      <= sy_c.v;
				screen.screen_depth  <= sz_c.v;
				screen.w_zero        <= 1'b0;
				screen.clipped_range <= sx_c.f || sy_c.f || sz_c.f;
			end
		end
	end

endmodule

// ----- rtl/vpts_checker.sv -----
`timescale 1ns / 1ps
module vpts_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input vpts_pkg::coord_t       sx,
	input vpts_pkg::coord_t       sy,
	input vpts_pkg::coord_t       sz,
	input logic                   wz,
	input logic                   clip,
	input logic                   cfg_ready
);
	import vpts_pkg::*;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sx) && $stable(sy) && $stable(sz)
			&& $stable(wz) && $stable(clip))
		else $error("stalled result changed");

	// Zero clip w forces zero coordinates and no saturation flag.
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wz |-> sx == '0 && sy == '0 && sz == '0 && !clip)
		else $error("w_zero result not cleared");

	// A saturation flag means some coordinate sits at a range limit.
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clip |-> sx == CMAX || sx == CMIN || sy == CMAX || sy == CMIN
			|| sz == CMAX || sz == CMIN)
		else $error("clipped_range without a saturated coordinate");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind vertex_project_to_screen vpts_checker u_vpts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (screen.valid),
	.out_ready (screen.ready),
	.sx        (screen.screen_x),
	.sy        (screen.screen_y),
	.sz        (screen.screen_depth),
	.wz        (screen.w_zero),
	.clip      (screen.clipped_range),
	.cfg_ready (cfg.ready)
);
